FILE: hw/rtl/xbgr_pkg.sv
// Shared types and constants for the XBGR32 pixel format converter.
// No dependencies; used by the lane, merge and top-level modules.
package xbgr_pkg;

    typedef enum logic [1:0] {
        MODE_XBGR32 = 2'd0,
        MODE_RGB24  = 2'd1,
        MODE_YUYV   = 2'd2,
        MODE_RSVD   = 2'd3
    } mode_t;

    localparam int SumW = 18;

    // BT.601 studio-swing coefficients (signed fixed point, scaled by 256).
    localparam logic signed [SumW-1:0] CoefYR = 18'sd66;
    localparam logic signed [SumW-1:0] CoefYG = 18'sd129;
    localparam logic signed [SumW-1:0] CoefYB = 18'sd25;
    localparam logic signed [SumW-1:0] CoefUR = -18'sd38;
    localparam logic signed [SumW-1:0] CoefUG = -18'sd74;
    localparam logic signed [SumW-1:0] CoefUB = 18'sd112;
    localparam logic signed [SumW-1:0] CoefVR = 18'sd112;
    localparam logic signed [SumW-1:0] CoefVG = -18'sd94;
    localparam logic signed [SumW-1:0] CoefVB = -18'sd18;
    localparam logic signed [SumW-1:0] RoundBias = 18'sd128;
    localparam logic [7:0] LumaOffset   = 8'd16;
    localparam logic [7:0] ChromaOffset = 8'd128;

    localparam logic [3:0] CountXbgr32 = 4'd8;
    localparam logic [3:0] CountRgb24  = 4'd6;
    localparam logic [3:0] CountYuyv   = 4'd4;

    // Converted components of one pixel.
    typedef struct packed {
        logic [7:0] y;
        logic [7:0] u;
        logic [7:0] v;
    } yuv_t;

    // Item as held in the first pipeline stage.
    typedef struct packed {
        mode_t       mode;
        logic [31:0] first_pixel;
        logic [31:0] second_pixel;
        logic        frame_end;
    } stage_t;

endpackage

FILE: hw/rtl/xbgr32_pixel_format_converter.sv
// Top level of the XBGR32 pixel format converter: handshake control, mode
// register and two conversion lanes. Depends on xbgr_pkg, xbgr_lane, xbgr_merge.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one pixel pair per
//   transaction: first_pixel, second_pixel (B,G,R,X bytes) and frame_end_in.
//   Output channel (out_valid / out_stall) returns one result per input
//   transaction: out_bytes, byte_count and frame_end_out, in input order.
//   cfg_wr_en / cfg_wr_data write the 2-bit output mode (0 XBGR32 pass,
//   1 RGB24, 2 YUYV, 3 behaves as pass); write it only while the block is idle.
// Pipeline and throughput:
//   Two register stages: one for the lanes, one for the merged output.
//   Each taken transaction passes the first stage, then the output register.
//   One pair per clock while out_stall is low; both lanes convert in parallel.
// Reset:
//   rst_n clears both stage valid flags and sets the mode to pass-through.
// Stalls:
//   When out_stall is high the output holds; the first stage still takes one
//   more transaction, after which in_stall rises until the output drains.
module xbgr32_pixel_format_converter (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_wr_data,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [31:0]  first_pixel,
    input  logic [31:0]  second_pixel,
    input  logic         frame_end_in,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [63:0]  out_bytes,
    output logic [3:0]   byte_count,
    output logic         frame_end_out
);

    xbgr_pkg::mode_t    mode_reg;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    xbgr_pkg::stage_t   s1_reg;
    xbgr_pkg::yuv_t     lane0_yuv;
    xbgr_pkg::yuv_t     lane1_yuv;
    logic               out_load;
    logic               s1_load;
    logic               in_take;

    // Output register loads when stage one is full and it is empty or draining.
    assign out_load = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !out_load;
    assign in_take  = in_valid && !in_stall;
    assign s1_load  = in_take;

    always_comb
    begin
        s1_valid_next = in_take || (s1_valid_reg && !out_load);
        out_valid_next = out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= xbgr_pkg::MODE_XBGR32;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= xbgr_pkg::mode_t'(cfg_wr_data);
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_reg.mode         <= mode_reg;
            s1_reg.first_pixel  <= first_pixel;
            s1_reg.second_pixel <= second_pixel;
            s1_reg.frame_end    <= frame_end_in;
        end
    end

    xbgr_lane u_lane0 (
        .clk   (clk),
        .load  (s1_load),
        .pixel (first_pixel),
        .yuv   (lane0_yuv)
    );

    xbgr_lane u_lane1 (
        .clk   (clk),
        .load  (s1_load),
        .pixel (second_pixel),
        .yuv   (lane1_yuv)
    );

    xbgr_merge u_merge (
        .clk           (clk),
        .load          (out_load),
        .stage         (s1_reg),
        .lane0         (lane0_yuv),
        .lane1         (lane1_yuv),
        .out_bytes     (out_bytes),
        .byte_count    (byte_count),
        .frame_end_out (frame_end_out)
    );

    assign out_valid = out_valid_reg;

    // An empty first stage must never hold off the source.
    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled while the first stage is empty");

    a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_count == 4'd4 || byte_count == 4'd6 || byte_count == 4'd8))
        else $error("illegal byte count on output");

    a_yuyv_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && byte_count == 4'd4) |-> (out_bytes[63:32] == 32'd0))
        else $error("YUYV result has nonzero unused bytes");

    a_rgb_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && byte_count == 4'd6) |-> (out_bytes[63:48] == 16'd0))
        else $error("RGB24 result has nonzero unused bytes");

    // A first-stage item with a free output must reach the output next cycle.
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_stall) |=> out_valid)
        else $error("first-stage item did not advance to the output");

endmodule

FILE: hw/rtl/xbgr_lane.sv
// One color-conversion lane: turns an XBGR32 pixel into registered Y, U, V.
// Depends on xbgr_pkg for coefficients and the yuv_t result type.
module xbgr_lane (
    input  logic              clk,
    input  logic              load,
    input  logic [31:0]       pixel,
    output xbgr_pkg::yuv_t    yuv
);

    logic signed [xbgr_pkg::SumW-1:0] b_s;
    logic signed [xbgr_pkg::SumW-1:0] g_s;
    logic signed [xbgr_pkg::SumW-1:0] r_s;
    logic signed [xbgr_pkg::SumW-1:0] y_sum;
    logic signed [xbgr_pkg::SumW-1:0] u_sum;
    logic signed [xbgr_pkg::SumW-1:0] v_sum;
    logic signed [xbgr_pkg::SumW-1:0] y_shr;
    logic signed [xbgr_pkg::SumW-1:0] u_shr;
    logic signed [xbgr_pkg::SumW-1:0] v_shr;
    xbgr_pkg::yuv_t                   yuv_next;
    xbgr_pkg::yuv_t                   yuv_reg;

    always_comb
    begin
        b_s = signed'({10'd0, pixel[7:0]});
        g_s = signed'({10'd0, pixel[15:8]});
        r_s = signed'({10'd0, pixel[23:16]});

        y_sum = xbgr_pkg::CoefYR * r_s + xbgr_pkg::CoefYG * g_s
              + xbgr_pkg::CoefYB * b_s + xbgr_pkg::RoundBias;
        u_sum = xbgr_pkg::CoefUR * r_s + xbgr_pkg::CoefUG * g_s
              + xbgr_pkg::CoefUB * b_s + xbgr_pkg::RoundBias;
        v_sum = xbgr_pkg::CoefVR * r_s + xbgr_pkg::CoefVG * g_s
              + xbgr_pkg::CoefVB * b_s + xbgr_pkg::RoundBias;

        // Floor shift; the offset add wraps into the byte like the scoreboard.
        y_shr = y_sum >>> 8;
        u_shr = u_sum >>> 8;
        v_shr = v_sum >>> 8;

        yuv_next.y = y_shr[7:0] + xbgr_pkg::LumaOffset;
        yuv_next.u = u_shr[7:0] + xbgr_pkg::ChromaOffset;
        yuv_next.v = v_shr[7:0] + xbgr_pkg::ChromaOffset;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            yuv_reg <= yuv_next;
        end
    end

    assign yuv = yuv_reg;

endmodule

FILE: hw/rtl/xbgr_merge.sv
// Merge stage: packs the lane results or the source bytes by mode into the
// output register. Depends on xbgr_pkg for the mode codes and stage types.
module xbgr_merge (
    input  logic                clk,
    input  logic                load,
    input  xbgr_pkg::stage_t    stage,
    input  xbgr_pkg::yuv_t      lane0,
    input  xbgr_pkg::yuv_t      lane1,
    output logic [63:0]         out_bytes,
    output logic [3:0]          byte_count,
    output logic                frame_end_out
);

    logic [63:0] bytes_next;
    logic [3:0]  count_next;
    logic [63:0] bytes_reg;
    logic [3:0]  count_reg;
    logic        frame_end_reg;

    always_comb
    begin
        case (stage.mode)
            xbgr_pkg::MODE_RGB24:
            begin
                bytes_next = {16'd0,
                              stage.second_pixel[7:0], stage.second_pixel[15:8],
                              stage.second_pixel[23:16],
                              stage.first_pixel[7:0], stage.first_pixel[15:8],
                              stage.first_pixel[23:16]};
                count_next = xbgr_pkg::CountRgb24;
            end
            xbgr_pkg::MODE_YUYV:
            begin
                // Chroma is taken from the first pixel only.
                bytes_next = {32'd0, lane0.v, lane1.y, lane0.u, lane0.y};
                count_next = xbgr_pkg::CountYuyv;
            end
            default:
            begin
                bytes_next = {stage.second_pixel, stage.first_pixel};
                count_next = xbgr_pkg::CountXbgr32;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg     <= bytes_next;
            count_reg     <= count_next;
            frame_end_reg <= stage.frame_end;
        end
    end

    assign out_bytes     = bytes_reg;
    assign byte_count    = count_reg;
    assign frame_end_out = frame_end_reg;

endmodule

FILE: test/xbgr32_conversion_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the XBGR32 pixel format converter: it follows mode writes, predicts
// each output transaction and compares it with the output channel field by field.
// Depends on xbgr_pkg for the mode encoding and the byte counts.
module xbgr32_conversion_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [31:0] first_pixel,
    input  logic [31:0] second_pixel,
    input  logic        frame_end_in,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [63:0] out_bytes,
    input  logic [3:0]  byte_count,
    input  logic        frame_end_out,
    output int          mismatch_count,
    output int          results_pending
);

    typedef struct packed {
        logic [63:0] bytes;
        logic [3:0]  count;
        logic        frame_end;
    } converted_t;

    converted_t      predicted_results[$];
    converted_t      want;
    converted_t      got;
    xbgr_pkg::mode_t cur_mode;
    int              errors = 0;

    // Round, floor-shift by 8 and add the component offset.
    function automatic logic [7:0] scale_601(input int sum, input int offset);
        int t;
        t = ((sum + 128) >>> 8) + offset;
        return t[7:0];
    endfunction

    function automatic converted_t convert_pair(input xbgr_pkg::mode_t mode,
                                                input logic [31:0] p0,
                                                input logic [31:0] p1, input logic fe);
        converted_t res;
        int r0, g0, b0, r1, g1, b1;
        logic [7:0] y0, y1, u, v;
        r0 = int'(p0[23:16]);
        g0 = int'(p0[15:8]);
        b0 = int'(p0[7:0]);
        r1 = int'(p1[23:16]);
        g1 = int'(p1[15:8]);
        b1 = int'(p1[7:0]);
        res.frame_end = fe;
        case (mode)
            xbgr_pkg::MODE_RGB24:
            begin
                res.bytes = {16'h0, p1[7:0], p1[15:8], p1[23:16],
                             p0[7:0], p0[15:8], p0[23:16]};
                res.count = xbgr_pkg::CountRgb24;
            end
            xbgr_pkg::MODE_YUYV:
            begin
                y0 = scale_601(66 * r0 + 129 * g0 + 25 * b0, 16);
                y1 = scale_601(66 * r1 + 129 * g1 + 25 * b1, 16);
                // Chroma is taken from the first pixel of the pair only.
                u  = scale_601(-38 * r0 - 74 * g0 + 112 * b0, 128);
                v  = scale_601(112 * r0 - 94 * g0 - 18 * b0, 128);
                res.bytes = {32'h0, v, y1, u, y0};
                res.count = xbgr_pkg::CountYuyv;
            end
            default:
            begin
                // The reserved mode behaves as pass-through.
                res.bytes = {p1, p0};
                res.count = xbgr_pkg::CountXbgr32;
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_mode = xbgr_pkg::MODE_XBGR32;
            predicted_results.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.bytes     = out_bytes;
                got.count     = byte_count;
                got.frame_end = frame_end_out;
                if (predicted_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected output transaction bytes %h count %0d",
                                 $time, got.bytes, got.count);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (got.bytes !== want.bytes || got.count !== want.count ||
                        got.frame_end !== want.frame_end)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("%0t: mismatch (expected/actual)", $time);
                            $display("  bytes %h/%h count %0d/%0d frame_end %0b/%0b",
                                     want.bytes, got.bytes, want.count, got.count,
                                     want.frame_end, got.frame_end);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
                predicted_results.push_back(convert_pair(cur_mode, first_pixel,
                                                         second_pixel, frame_end_in));
            if (cfg_wr_en)
                cur_mode = xbgr_pkg::mode_t'(cfg_wr_data);
        end
        mismatch_count  <= errors;
        results_pending <= predicted_results.size();
    end

endmodule

FILE: test/xbgr32_pixel_format_converter_tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the XBGR32 pixel format converter.
// Depends on xbgr_pkg, the converter RTL and xbgr32_conversion_checker.
module xbgr32_pixel_format_converter_tb;

    localparam int HoldCycles = 400;
    localparam int QuietLimit = 4000;
    localparam int BlockItems = 90;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_wr_en    = 1'b0;
    logic [1:0]  cfg_wr_data  = 2'd0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [31:0] first_pixel  = 32'h0;
    logic [31:0] second_pixel = 32'h0;
    logic        frame_end_in = 1'b0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        frame_end_out;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_granted = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int mismatch_count;
    int results_pending;
    xbgr_pkg::mode_t mode_order [5];

    always #5 clk = ~clk;

    xbgr32_pixel_format_converter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .first_pixel   (first_pixel),
        .second_pixel  (second_pixel),
        .frame_end_in  (frame_end_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_bytes     (out_bytes),
        .byte_count    (byte_count),
        .frame_end_out (frame_end_out)
    );

    xbgr32_conversion_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .first_pixel     (first_pixel),
        .second_pixel    (second_pixel),
        .frame_end_in    (frame_end_in),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_bytes       (out_bytes),
        .byte_count      (byte_count),
        .frame_end_out   (frame_end_out),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // Output side: random stalls, plus long hold-offs on request so the pipeline fills.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (holds_granted != hold_requests)
        begin
            holds_granted++;
            hold_left = HoldCycles - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QuietLimit)
            begin
                $display("watchdog: no transaction for %0d cycles", QuietLimit);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Bytes are biased toward 0x00 and 0xFF so the color extremes come up often.
    function automatic logic [31:0] rand_pixel();
        logic [31:0] px;
        int k;
        for (k = 0; k < 4; k++)
        begin
            case ($urandom_range(3))
                0:       px[8*k +: 8] = 8'h00;
                1:       px[8*k +: 8] = 8'hFF;
                default: px[8*k +: 8] = 8'($urandom);
            endcase
        end
        return px;
    endfunction

    task automatic send_pair(input logic [31:0] p0, input logic [31:0] p1, input logic fe);
        // Each cycle the sender idles with the current probability.
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        first_pixel  <= p0;
        second_pixel <= p1;
        frame_end_in <= fe;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // The mode may only change once every outstanding transaction has come out.
    task automatic drain_and_set_mode(input xbgr_pkg::mode_t m);
        @(negedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        int phase;
        int blk;
        int k;
        mode_order = '{xbgr_pkg::MODE_YUYV, xbgr_pkg::MODE_RGB24, xbgr_pkg::MODE_XBGR32,
                       xbgr_pkg::MODE_RSVD, xbgr_pkg::MODE_YUYV};
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Pass-through straight out of reset.
        send_pair(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_pair(32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0);

        drain_and_set_mode(xbgr_pkg::MODE_YUYV);
        send_pair(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        send_pair(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        send_pair(32'h00FF_0000, 32'h0000_00FF, 1'b0);
        send_pair(32'h0000_00FF, 32'h00FF_0000, 1'b0);
        send_pair(32'h0000_FF00, 32'h00FF_FF00, 1'b0);
        send_pair(32'h00FF_00FF, 32'h0000_FFFF, 1'b0);
        // The X byte must not leak into the converted values.
        send_pair(32'hFF00_0000, 32'h00FF_FFFF, 1'b1);

        drain_and_set_mode(xbgr_pkg::MODE_RGB24);
        send_pair(32'hFF12_3456, 32'h00AB_CDEF, 1'b0);
        send_pair(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        send_pair(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);

        drain_and_set_mode(xbgr_pkg::MODE_RSVD);
        send_pair(32'h89AB_CDEF, 32'h0123_4567, 1'b0);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

        // Random frames under three idling patterns, each one cycling through the modes.
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 83 : 0;
            recv_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 8 : 0;
            for (blk = 0; blk < 5; blk++)
            begin
                drain_and_set_mode(mode_order[blk]);
                for (k = 0; k < BlockItems; k++)
                begin
                    if (phase == 2 && blk == 0 && k == 30)
                        hold_requests++;
                    send_pair(rand_pixel(), rand_pixel(),
                              (k == BlockItems - 1) || ($urandom_range(15) == 0));
                end
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: xbgr32_pixel_format_converter.f
hw/rtl/xbgr_pkg.sv
hw/rtl/xbgr_lane.sv
hw/rtl/xbgr_merge.sv
hw/rtl/xbgr32_pixel_format_converter.sv
test/xbgr32_conversion_checker.sv
test/xbgr32_pixel_format_converter_tb.sv
